@@ sv/lmcf_pkg.sv @@
// ============================================================================
// Lens motor command framer package
// Shared types, frame constants and hex conversion helpers.
// ============================================================================
`default_nettype none

package lmcf_pkg;

  // Command kind codes as they arrive on the input port.
  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_ALL    = 2'd1;
  localparam logic [1:0] KIND_CAL    = 2'd2;

  // Highest valid single move axis.
  localparam logic [1:0] AXIS_MAX = 2'd2;

  // Frame characters.
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  // Byte counter width (longest frame is twenty bytes).
  localparam int unsigned IDX_W = 5;

  // Frame lengths and offsets inside a frame.
  localparam logic [IDX_W-1:0] LEN_CAL      = 5'd8;
  localparam logic [IDX_W-1:0] LEN_SINGLE   = 5'd12;
  localparam logic [IDX_W-1:0] LEN_ALL      = 5'd20;
  localparam logic [IDX_W-1:0] DATA_SINGLE  = 5'd8;
  localparam logic [IDX_W-1:0] DATA_ALL     = 5'd16;
  localparam logic [IDX_W-1:0] OFS_MOTOR    = 5'd3;
  localparam logic [IDX_W-1:0] OFS_POS      = 5'd4;

  // Frame types handed from the front end to the back end.
  typedef enum logic [1:0] {
    FT_SINGLE = 2'd0,
    FT_ALL    = 2'd1,
    FT_CAL    = 2'd2
  } frame_type_t;

  // One classified command, ready to be serialized.
  typedef struct packed {
    frame_type_t ftype;
    logic [7:0]  motor_char;
    logic [15:0] pos_a;
    logic [15:0] pos_b;
    logic [15:0] pos_c;
  } cmd_desc_t;

  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = CH_ZERO + {4'd0, nib};
    end else begin
      res = 8'h37 + {4'd0, nib};
    end
    return res;
  endfunction

  function automatic logic [7:0] hex_lower(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = CH_ZERO + {4'd0, nib};
    end else begin
      res = 8'h57 + {4'd0, nib};
    end
    return res;
  endfunction

  // Fixed calibrate frame: '@','0','F','F','7','0',CR,LF.
  function automatic logic [7:0] cal_byte(input logic [2:0] idx);
    logic [7:0] res;
    case (idx)
      3'd0: res = CH_AT;
      3'd1: res = CH_ZERO;
      3'd2: res = CH_F;
      3'd3: res = CH_F;
      3'd4: res = CH_SEVEN;
      3'd5: res = CH_ZERO;
      3'd6: res = CH_CR;
      3'd7: res = CH_LF;
      default: res = CH_LF;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/lmcf_front.sv @@
// ============================================================================
// Lens motor command framer front end
// Classifies an accepted command and drops those that yield no frame.
// ============================================================================
`default_nettype none

module lmcf_front (
  input  wire logic             accept,
  input  wire logic             link_enabled,
  input  wire logic [1:0]       kind,
  input  wire logic [1:0]       axis,
  input  wire logic [15:0]      position_a,
  input  wire logic [15:0]      position_b,
  input  wire logic [15:0]      position_c,
  output logic                  push,
  output lmcf_pkg::cmd_desc_t   desc
);

  logic keep;

  always_comb begin
    keep            = 1'b0;
    desc.ftype      = lmcf_pkg::FT_CAL;
    desc.motor_char = lmcf_pkg::CH_SEVEN;
    desc.pos_a      = position_a;
    desc.pos_b      = position_b;
    desc.pos_c      = position_c;
    case (kind)
      lmcf_pkg::KIND_SINGLE: begin
        keep            = link_enabled && (axis <= lmcf_pkg::AXIS_MAX);
        desc.ftype      = lmcf_pkg::FT_SINGLE;
        desc.motor_char = lmcf_pkg::CH_ONE + {6'd0, axis};
      end
      lmcf_pkg::KIND_ALL: begin
        keep       = link_enabled;
        desc.ftype = lmcf_pkg::FT_ALL;
      end
      lmcf_pkg::KIND_CAL: begin
        // Calibration goes out even while the link is closed.
        keep       = 1'b1;
        desc.ftype = lmcf_pkg::FT_CAL;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

endmodule

`default_nettype wire

@@ sv/lmcf_queue.sv @@
// ============================================================================
// Lens motor command framer command queue
// Two-entry FIFO of classified commands between front and back ends.
// ============================================================================
`default_nettype none

module lmcf_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire lmcf_pkg::cmd_desc_t push_desc,
  input  wire logic                pop,
  output logic                     full,
  output logic                     not_empty,
  output lmcf_pkg::cmd_desc_t      head
);

  lmcf_pkg::cmd_desc_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

@@ sv/lmcf_back.sv @@
// ============================================================================
// Lens motor command framer back end
// Serializes the queued command one frame byte per cycle with running BCC.
// ============================================================================
`default_nettype none

module lmcf_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cmd_valid,
  input  wire lmcf_pkg::cmd_desc_t cmd,
  output logic                     pop,
  output logic                     out_valid,
  output logic [7:0]               out_frame_byte,
  output logic                     out_frame_end
);

  logic [lmcf_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]                 bcc_r, bcc_nxt;
  logic                       valid_r, valid_nxt;
  logic [7:0]                 byte_r, byte_nxt;
  logic                       end_r, end_nxt;

  logic [lmcf_pkg::IDX_W-1:0] frame_len;
  logic [lmcf_pkg::IDX_W-1:0] data_len;
  logic [lmcf_pkg::IDX_W-1:0] pos_ofs;
  logic [15:0]                pos_sel;
  logic [3:0]                 nib;
  logic [7:0]                 cur_byte;
  logic                       last;

  always_comb begin
    case (cmd.ftype)
      lmcf_pkg::FT_SINGLE: begin
        frame_len = lmcf_pkg::LEN_SINGLE;
        data_len  = lmcf_pkg::DATA_SINGLE;
      end
      lmcf_pkg::FT_ALL: begin
        frame_len = lmcf_pkg::LEN_ALL;
        data_len  = lmcf_pkg::DATA_ALL;
      end
      default: begin
        frame_len = lmcf_pkg::LEN_CAL;
        data_len  = lmcf_pkg::LEN_CAL;
      end
    endcase
  end

  // Position digit: four digits per position, low byte first, high nibble first.
  always_comb begin
    pos_ofs = idx_r - lmcf_pkg::OFS_POS;
    case (pos_ofs[3:2])
      2'd0:    pos_sel = cmd.pos_a;
      2'd1:    pos_sel = cmd.pos_b;
      default: pos_sel = cmd.pos_c;
    endcase
    case (pos_ofs[1:0])
      2'd0:    nib = pos_sel[7:4];
      2'd1:    nib = pos_sel[3:0];
      2'd2:    nib = pos_sel[15:12];
      default: nib = pos_sel[11:8];
    endcase
  end

  always_comb begin
    if (cmd.ftype == lmcf_pkg::FT_CAL) begin
      cur_byte = lmcf_pkg::cal_byte(idx_r[2:0]);
    end else if (idx_r == 5'd0) begin
      cur_byte = lmcf_pkg::CH_AT;
    end else if (idx_r == 5'd1) begin
      cur_byte = lmcf_pkg::CH_ONE;
    end else if (idx_r == 5'd2) begin
      cur_byte = lmcf_pkg::CH_ZERO;
    end else if (idx_r == lmcf_pkg::OFS_MOTOR) begin
      cur_byte = cmd.motor_char;
    end else if (idx_r < data_len) begin
      cur_byte = lmcf_pkg::hex_upper(nib);
    end else if (idx_r == data_len) begin
      cur_byte = lmcf_pkg::hex_lower(bcc_r[7:4]);
    end else if (idx_r == data_len + 5'd1) begin
      cur_byte = lmcf_pkg::hex_lower(bcc_r[3:0]);
    end else if (idx_r == data_len + 5'd2) begin
      cur_byte = lmcf_pkg::CH_CR;
    end else begin
      cur_byte = lmcf_pkg::CH_LF;
    end
  end

  assign last = (idx_r == frame_len - 5'd1);
  assign pop  = cmd_valid && last;

  always_comb begin
    idx_nxt   = idx_r;
    bcc_nxt   = bcc_r;
    valid_nxt = cmd_valid;
    byte_nxt  = cur_byte;
    end_nxt   = cmd_valid && last;
    if (cmd_valid) begin
      if (last) begin
        idx_nxt = '0;
        bcc_nxt = 8'd0;
      end else begin
        idx_nxt = idx_r + 5'd1;
        if (idx_r < data_len) begin
          bcc_nxt = bcc_r ^ cur_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      bcc_r   <= 8'd0;
      valid_r <= 1'b0;
      end_r   <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      bcc_r   <= bcc_nxt;
      valid_r <= valid_nxt;
      end_r   <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign out_valid      = valid_r;
  assign out_frame_byte = byte_r;
  assign out_frame_end  = end_r;

endmodule

`default_nettype wire

@@ sv/lens_motor_command_framer_core.sv @@
// ============================================================================
// Lens motor command framer core
// Turns lens motor commands into ASCII frames with an XOR BCC, one byte out
// per clock cycle.
// ============================================================================
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------------------
//   in       start / busy           in_kind, in_axis, in_position_a/b/c
//   out      out_valid (strobe)     out_frame_byte, out_frame_end
//   cfg      cfg_wr_en              cfg_wr_data (link_enabled)
//
// A command beat is taken when start is high and busy is low. The back end
// emits one frame byte per cycle: a calibrate frame is 8 bytes long, a single
// axis move 12 and an all axes move 20, and frames follow one another with no
// gap while commands are queued. The two-entry command queue sets how far the
// front end runs ahead; busy is high only while both entries are held.
// A command that reaches an empty queue is registered in it, then its first
// byte is registered in the back end. Reset is synchronous and active low;
// it empties the queue and clears the link enable. The receiver cannot stall
// the output, so each byte strobe lasts exactly one cycle.
// ============================================================================
`default_nettype none

module lens_motor_command_framer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command input.
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [1:0]  in_axis,
  input  wire logic [15:0] in_position_a,
  input  wire logic [15:0] in_position_b,
  input  wire logic [15:0] in_position_c,
  // Frame byte output.
  output logic             out_valid,
  output logic [7:0]       out_frame_byte,
  output logic             out_frame_end,
  // Configuration.
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data
);

  logic                link_enabled_r, link_enabled_nxt;
  logic                accept;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_not_empty;
  lmcf_pkg::cmd_desc_t push_desc;
  lmcf_pkg::cmd_desc_t head_desc;

  // The link enable is sampled when a command is accepted, so a closed link
  // drops position commands right at the front end.
  assign link_enabled_nxt = cfg_wr_en ? cfg_wr_data : link_enabled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_enabled_r <= 1'b0;
    end else begin
      link_enabled_r <= link_enabled_nxt;
    end
  end

  assign busy   = q_full;
  assign accept = start && !busy;

  // Front end: classify the command, discard the ones that give no frame.
  lmcf_front u_front (
    .accept       (accept),
    .link_enabled (link_enabled_r),
    .kind         (in_kind),
    .axis         (in_axis),
    .position_a   (in_position_a),
    .position_b   (in_position_b),
    .position_c   (in_position_c),
    .push         (push),
    .desc         (push_desc)
  );

  // Queue decouples acceptance from serialization.
  lmcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_desc)
  );

  // Back end: one frame byte per cycle, BCC accumulated along the way, the
  // queue entry released on the final LF byte.
  lmcf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (q_not_empty),
    .cmd            (head_desc),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end)
  );

endmodule

`default_nettype wire

@@ test/lens_motor_command_framer_core_tb.sv @@
// ============================================================================
// Lens motor command framer core testbench
// Drives move and calibrate commands through the start/busy port and checks
// every frame byte strobe against a frame builder kept inside the bench.
// ============================================================================
`timescale 1ns / 100ps

module lens_motor_command_framer_core_tb;

  import lmcf_pkg::*;

  // One expected output beat: a frame byte and the end-of-frame marker.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  // One directed command. When typed is set, body holds the frame without
  // CR LF, right-aligned and zero-padded; an all-zero body means the command
  // must produce nothing at all.
  typedef struct packed {
    logic         link;
    logic         typed;
    logic [1:0]   kind;
    logic [1:0]   axis;
    logic [15:0]  pos_a;
    logic [15:0]  pos_b;
    logic [15:0]  pos_c;
    logic [143:0] body;
  } probe_row_t;

  localparam int NUM_PROBES     = 18;
  localparam int NUM_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 34;
  // Longest frame is 20 beats, plus the queue and output registers, so this
  // many quiet cycles is enough for any straggling byte to show up.
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic [1:0] AXIS_UNKNOWN = 2'd3;

  localparam logic [127:0] UPPER_DIGITS = "0123456789ABCDEF";
  localparam logic [127:0] LOWER_DIGITS = "0123456789abcdef";

  // The directed part: reset state with the link closed, calibrate regardless
  // of the link, unknown kind and unknown axis, position extremes, and frames
  // whose bytes are simple enough to write down by hand.
  localparam probe_row_t PROBES [NUM_PROBES] = '{
    '{1'b0, 1'b1, KIND_SINGLE,  2'd0, 16'h1234, 16'h0000, 16'h0000, ""},
    '{1'b0, 1'b1, KIND_ALL,     2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, ""},
    '{1'b0, 1'b1, KIND_CAL,     2'd0, 16'h0000, 16'h0000, 16'h0000, "@0FF70"},
    '{1'b0, 1'b1, KIND_UNKNOWN, 2'd0, 16'h0000, 16'h0000, 16'h0000, ""},
    '{1'b1, 1'b1, KIND_CAL,     2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, "@0FF70"},
    '{1'b1, 1'b1, KIND_SINGLE,  2'd0, 16'h0000, 16'h0000, 16'h0000,
      {"@10", "1", "0000", "70"}},
    '{1'b1, 1'b1, KIND_SINGLE,  2'd2, 16'hFFFF, 16'h0000, 16'h0000,
      {"@10", "3", "FFFF", "72"}},
    '{1'b1, 1'b0, KIND_SINGLE,  2'd1, 16'h12AB, 16'h0000, 16'h0000, ""},
    '{1'b1, 1'b1, KIND_SINGLE,  2'd3, 16'h5555, 16'hAAAA, 16'h5555, ""},
    '{1'b1, 1'b1, KIND_UNKNOWN, 2'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, ""},
    '{1'b1, 1'b1, KIND_ALL,     2'd0, 16'h0000, 16'h0000, 16'h0000,
      {"@107", "0000", "0000", "0000", "76"}},
    '{1'b1, 1'b1, KIND_ALL,     2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      {"@107", "FFFF", "FFFF", "FFFF", "76"}},
    '{1'b1, 1'b0, KIND_ALL,     2'd1, 16'h5A3C, 16'hC35A, 16'h0F0F, ""},
    '{1'b1, 1'b0, KIND_SINGLE,  2'd0, 16'h8001, 16'h0000, 16'h0000, ""},
    '{1'b1, 1'b0, KIND_ALL,     2'd2, 16'h0001, 16'h8000, 16'h7FFE, ""},
    '{1'b0, 1'b1, KIND_SINGLE,  2'd3, 16'hFFFF, 16'h0000, 16'h0000, ""},
    '{1'b0, 1'b1, KIND_ALL,     2'd0, 16'h0001, 16'h0002, 16'h0003, ""},
    '{1'b0, 1'b1, KIND_CAL,     2'd1, 16'hBEEF, 16'hCAFE, 16'hF00D, "@0FF70"}
  };

  // Random phases: how often the sender pauses between commands, and the
  // link setting written before the phase starts. The receiver cannot stall
  // this block, so the phases without sender pauses run without any idling.
  localparam int   IDLE_PCT  [NUM_PHASES] = '{0, 55, 0, 19, 55, 19};
  localparam logic LINK_OPEN [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [1:0]  in_axis;
  logic [15:0] in_position_a;
  logic [15:0] in_position_b;
  logic [15:0] in_position_c;
  logic        out_valid;
  logic [7:0]  out_frame_byte;
  logic        out_frame_end;
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  // Bench copy of the link enable register, updated on every write.
  logic        link_open;
  // Frame bytes the block still owes us, oldest first.
  frame_beat_t pending_bytes [$];
  bit          mismatch_seen;
  int          quiet_cycles;

  lens_motor_command_framer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_axis        (in_axis),
    .in_position_a  (in_position_a),
    .in_position_b  (in_position_b),
    .in_position_c  (in_position_c),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (upper) begin
      return UPPER_DIGITS[(15 - nib) * 8 +: 8];
    end
    return LOWER_DIGITS[(15 - nib) * 8 +: 8];
  endfunction

  // Appends a finished frame to the expectation queue; only the final LF
  // carries the end marker.
  function automatic void queue_frame(input logic [7:0] frame [$]);
    frame_beat_t beat;
    foreach (frame[i]) begin
      beat.data = frame[i];
      beat.last = (i == frame.size() - 1);
      pending_bytes.push_back(beat);
    end
  endfunction

  // Builds the frame a command should produce under the current link setting.
  // Positions go out as four uppercase digits, low byte first; the BCC is the
  // XOR of everything before it, as two lowercase digits.
  function automatic void predict_frame(input logic [1:0] kind, input logic [1:0] axis,
                                        input logic [15:0] pos_a, input logic [15:0] pos_b,
                                        input logic [15:0] pos_c);
    logic [7:0]  frame [$];
    logic [7:0]  bcc;
    logic [15:0] pos;
    int          n_pos;
    case (kind)
      KIND_CAL: begin
        frame = '{CH_AT, CH_ZERO, CH_F, CH_F, CH_SEVEN, CH_ZERO};
      end
      KIND_SINGLE, KIND_ALL: begin
        if (!link_open) begin
          return;
        end
        if (kind == KIND_SINGLE && axis > AXIS_MAX) begin
          return;
        end
        frame = '{CH_AT, CH_ONE, CH_ZERO};
        if (kind == KIND_SINGLE) begin
          frame.push_back(CH_ONE + {6'd0, axis});
          n_pos = 1;
        end else begin
          frame.push_back(CH_SEVEN);
          n_pos = 3;
        end
        for (int p = 0; p < n_pos; p++) begin
          pos = (p == 0) ? pos_a : (p == 1) ? pos_b : pos_c;
          frame.push_back(hex_char(pos[7:4], 1'b1));
          frame.push_back(hex_char(pos[3:0], 1'b1));
          frame.push_back(hex_char(pos[15:12], 1'b1));
          frame.push_back(hex_char(pos[11:8], 1'b1));
        end
        bcc = 8'h00;
        foreach (frame[i]) begin
          bcc ^= frame[i];
        end
        frame.push_back(hex_char(bcc[7:4], 1'b0));
        frame.push_back(hex_char(bcc[3:0], 1'b0));
      end
      default: begin
        // Unknown kinds are dropped by the block.
        return;
      end
    endcase
    frame.push_back(CH_CR);
    frame.push_back(CH_LF);
    queue_frame(frame);
  endfunction

  // Expectation written by hand in the directed table. An empty body means
  // the command must vanish without a single byte.
  function automatic void expect_literal(input logic [143:0] body);
    logic [7:0] frame [$];
    for (int i = 17; i >= 0; i--) begin
      if (body[i * 8 +: 8] != 8'h00) begin
        frame.push_back(body[i * 8 +: 8]);
      end
    end
    if (frame.size() != 0) begin
      frame.push_back(CH_CR);
      frame.push_back(CH_LF);
      queue_frame(frame);
    end
  endfunction

  // Presents one command at the falling edge and holds it until the block
  // takes the beat. Returns at the next falling edge with start still high,
  // so back-to-back commands keep start asserted without a dip.
  task automatic send_command(input logic [1:0] kind, input logic [1:0] axis,
                              input logic [15:0] pos_a, input logic [15:0] pos_b,
                              input logic [15:0] pos_c, input logic typed,
                              input logic [143:0] body);
    in_kind       = kind;
    in_axis       = axis;
    in_position_a = pos_a;
    in_position_b = pos_b;
    in_position_c = pos_c;
    start         = 1'b1;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    // The first byte must still pass the back end's output register, so queuing
    // the expectation here cannot race with the output checker.
    if (typed) begin
      expect_literal(body);
    end else begin
      predict_frame(kind, axis, pos_a, pos_b, pos_c);
    end
    @(negedge clk);
  endtask

  // Random sender gap. Most gaps are short; now and then one spans most of a
  // long frame so that pauses land on every part of the block's work.
  task automatic sender_gap(input int pct);
    int gap;
    if ($urandom_range(99) < pct) begin
      start = 1'b0;
      gap = ($urandom_range(3) == 0) ? $urandom_range(24, 1) : $urandom_range(3, 1);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Link enable writes happen only with the block idle: every owed byte has
  // arrived, and a further drain has passed after the last of them.
  task automatic write_link(input logic value);
    start = 1'b0;
    while (pending_bytes.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    link_open   = value;
  endtask

  function automatic logic [15:0] random_position();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Mostly well-formed moves and calibrates, with a sprinkling of unknown
  // kinds and unknown single-move axes.
  task automatic send_random_command();
    int         pick;
    logic [1:0] kind;
    logic [1:0] axis;
    pick = $urandom_range(99);
    if (pick < 40) begin
      kind = KIND_SINGLE;
      axis = ($urandom_range(9) == 0) ? AXIS_UNKNOWN : 2'($urandom_range(2));
    end else begin
      kind = (pick < 80) ? KIND_ALL : (pick < 92) ? KIND_CAL : KIND_UNKNOWN;
      axis = 2'($urandom_range(3));
    end
    send_command(kind, axis, random_position(), random_position(), random_position(),
                 1'b0, '0);
  endtask

  // Output checker: every strobe must match the oldest owed byte, field by
  // field. A strobe with nothing owed is a failure too.
  always @(posedge clk) begin : check_beat
    frame_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected frame byte 0x%02h (frame_end %0b)", out_frame_byte,
               out_frame_end);
        mismatch_seen = 1'b1;
      end else begin
        want = pending_bytes.pop_front();
        if (out_frame_byte !== want.data) begin
          $error("frame_byte: expected 0x%02h, got 0x%02h", want.data, out_frame_byte);
          mismatch_seen = 1'b1;
        end
        if (out_frame_end !== want.last) begin
          $error("frame_end: expected %0b, got %0b", want.last, out_frame_end);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // Watchdog: any accepted command beat or frame byte counts as progress.
  // The longest legal quiet stretch is a configuration or end-of-run drain,
  // far below the limit.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    probe_row_t row;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_kind       = KIND_SINGLE;
    in_axis       = 2'd0;
    in_position_a = 16'h0000;
    in_position_b = 16'h0000;
    in_position_c = 16'h0000;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    link_open     = 1'b0;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part. The first rows rely on the link being closed by reset.
    for (int i = 0; i < NUM_PROBES; i++) begin
      row = PROBES[i];
      if (row.link != link_open) begin
        write_link(row.link);
      end
      send_command(row.kind, row.axis, row.pos_a, row.pos_b, row.pos_c, row.typed,
                   row.body);
      sender_gap(30);
    end

    // Random part, phase by phase, with a link write at each phase boundary.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_link(LINK_OPEN[ph]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_random_command();
        sender_gap(IDLE_PCT[ph]);
      end
    end

    start = 1'b0;
    while (pending_bytes.size() != 0) begin
      @(negedge clk);
    end
    // Give any stray byte a chance to appear after the last expected one.
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (!mismatch_seen) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
